[rtl/dqcs_pkg.sv]
// package for the dual quadrature counter: payload types, widths, register indexes
`timescale 1ns / 1ps

package dqcs_pkg;

  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned TICK_WIDTH  = 16;
  localparam int unsigned WIN_WIDTH   = 16;
  localparam int unsigned CFG_WIDTH   = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CMP_WIDTH   = (TICK_WIDTH > WIN_WIDTH) ? TICK_WIDTH : WIN_WIDTH;

  localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_INVERT_LEFT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_RIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 2'd2;

  localparam logic [WIN_WIDTH-1:0] WINDOW_RESET = 16'd100;

  typedef struct packed {
    logic left_a;
    logic left_b;
    logic right_a;
    logic right_b;
    logic ms_tick;
  } in_t;

  typedef struct packed {
    logic signed [31:0] left_position;
    logic signed [31:0] right_position;
    logic signed [31:0] left_window_change;
    logic signed [31:0] right_window_change;
    logic               speed_update;
    logic        [31:0] left_a_edge_total;
    logic        [31:0] right_a_edge_total;
  } out_t;

  // sign-extend a count to 64 bits, then keep the low 32
  function automatic logic signed [31:0] to_out32(input logic [COUNT_WIDTH-1:0] v);
    logic signed [63:0] w;
    w = 64'(signed'(v));
    return w[31:0];
  endfunction

endpackage

[rtl/dual_quadrature_counter_speed.sv]
// top level of the dual quadrature counter with windowed speed measurement
`timescale 1ns / 1ps

// two-encoder x4 quadrature counter with a tick-based speed window.
// each input transfer carries one sample of the left and right a/b levels
// plus a millisecond tick strobe; each sample produces exactly one result
// transfer with both positions, the last window changes, an update pulse
// and the a-edge totals. the block sustains one sample per clock while the
// result side does not stall: a sample is held in the input register, is
// decoded and folded into the counters by single-pass logic, and lands in
// the result register; stalls on the result side back up through the input
// register. the first sample after reset only primes the stored levels.
// configuration (inversion per side, window length in ticks) is written by
// the user through cfg_we_i/cfg_idx_i/cfg_data_i only while no sample is in
// flight; the block does not enforce this. a window of zero ticks acts as one.

module dual_quadrature_counter_speed (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  dqcs_pkg::in_t                       in_data_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output dqcs_pkg::out_t                      out_data_o,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [dqcs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dqcs_pkg::CFG_WIDTH-1:0]      cfg_data_i
);

  localparam int unsigned CW = dqcs_pkg::COUNT_WIDTH;
  localparam int unsigned TW = dqcs_pkg::TICK_WIDTH;
  localparam int unsigned MW = dqcs_pkg::CMP_WIDTH;

  // configuration registers
  logic                              invert_left_q;
  logic                              invert_right_q;
  logic [dqcs_pkg::WIN_WIDTH-1:0]    window_ticks_q;

  // input register
  logic                              s1_valid_q;
  dqcs_pkg::in_t                     s1_data_q;

  // decode state
  logic [3:0]                        prev_levels_q, prev_levels_d;
  logic                              primed_q;
  logic [CW-1:0]                     left_count_q, left_count_d;
  logic [CW-1:0]                     right_count_q, right_count_d;
  logic [CW-1:0]                     left_start_q, left_start_d;
  logic [CW-1:0]                     right_start_q, right_start_d;
  logic [CW-1:0]                     left_change_q, left_change_d;
  logic [CW-1:0]                     right_change_q, right_change_d;
  logic [TW-1:0]                     tick_count_q, tick_count_d;
  logic [31:0]                       left_edges_q, left_edges_d;
  logic [31:0]                       right_edges_q, right_edges_d;
  logic                              update_d;

  // result register
  logic                              out_valid_q;
  dqcs_pkg::out_t                    out_data_q;

  logic                              out_free;
  logic                              s1_fire;
  logic                              in_fire;

  logic signed [CW-1:0]              left_step;
  logic signed [CW-1:0]              right_step;
  logic                              left_a_edge;
  logic                              right_a_edge;

  logic [TW-1:0]                     tick_inc;
  logic [MW-1:0]                     win_ext;
  logic [MW-1:0]                     win_eff;
  logic [MW-1:0]                     tick_max_ext;
  logic [MW-1:0]                     tick_inc_ext;

  // handshake: the result register frees when empty or being taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_left_q  <= 1'b1;
      invert_right_q <= 1'b0;
      window_ticks_q <= dqcs_pkg::WINDOW_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dqcs_pkg::REG_INVERT_LEFT:  invert_left_q  <= cfg_data_i[0];
        dqcs_pkg::REG_INVERT_RIGHT: invert_right_q <= cfg_data_i[0];
        dqcs_pkg::REG_WINDOW_TICKS: window_ticks_q <= cfg_data_i[dqcs_pkg::WIN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // per-side decoders against the stored levels
  dqcs_decode u_left (
    .old_a_i  (prev_levels_q[0]),
    .old_b_i  (prev_levels_q[1]),
    .new_a_i  (s1_data_q.left_a),
    .new_b_i  (s1_data_q.left_b),
    .invert_i (invert_left_q),
    .step_o   (left_step),
    .a_edge_o (left_a_edge)
  );

  dqcs_decode u_right (
    .old_a_i  (prev_levels_q[2]),
    .old_b_i  (prev_levels_q[3]),
    .new_a_i  (s1_data_q.right_a),
    .new_b_i  (s1_data_q.right_b),
    .invert_i (invert_right_q),
    .step_o   (right_step),
    .a_edge_o (right_a_edge)
  );

  // effective window: zero acts as one, clamp to the tick counter range
  always_comb begin
    win_ext      = MW'(window_ticks_q);
    tick_max_ext = MW'(dqcs_pkg::TICK_MAX);
    if (win_ext == '0) begin
      win_eff = MW'(1);
    end else if (win_ext > tick_max_ext) begin
      win_eff = tick_max_ext;
    end else begin
      win_eff = win_ext;
    end
    tick_inc     = (tick_count_q < dqcs_pkg::TICK_MAX) ? tick_count_q + TW'(1) : tick_count_q;
    tick_inc_ext = MW'(tick_inc);
  end

  // single-pass update of the counters for the sample in the input register
  always_comb begin
    prev_levels_d  = {s1_data_q.right_b, s1_data_q.right_a, s1_data_q.left_b, s1_data_q.left_a};
    left_count_d   = left_count_q;
    right_count_d  = right_count_q;
    left_start_d   = left_start_q;
    right_start_d  = right_start_q;
    left_change_d  = left_change_q;
    right_change_d = right_change_q;
    tick_count_d   = tick_count_q;
    left_edges_d   = left_edges_q;
    right_edges_d  = right_edges_q;
    update_d       = 1'b0;
    if (primed_q) begin
      left_count_d  = left_count_q + left_step;
      right_count_d = right_count_q + right_step;
      left_edges_d  = left_edges_q + 32'(left_a_edge);
      right_edges_d = right_edges_q + 32'(right_a_edge);
      if (s1_data_q.ms_tick) begin
        tick_count_d = tick_inc;
        // window closes: latch changes including this sample's steps
        if (tick_inc_ext >= win_eff) begin
          left_change_d  = left_count_d - left_start_q;
          right_change_d = right_count_d - right_start_q;
          left_start_d   = left_count_d;
          right_start_d  = right_count_d;
          tick_count_d   = '0;
          update_d       = 1'b1;
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_data_i;
    end
  end

  // decode state advances as the sample moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_levels_q  <= '0;
      primed_q       <= 1'b0;
      left_count_q   <= '0;
      right_count_q  <= '0;
      left_start_q   <= '0;
      right_start_q  <= '0;
      left_change_q  <= '0;
      right_change_q <= '0;
      tick_count_q   <= '0;
      left_edges_q   <= '0;
      right_edges_q  <= '0;
    end else if (s1_fire) begin
      prev_levels_q  <= prev_levels_d;
      primed_q       <= 1'b1;
      left_count_q   <= left_count_d;
      right_count_q  <= right_count_d;
      left_start_q   <= left_start_d;
      right_start_q  <= right_start_d;
      left_change_q  <= left_change_d;
      right_change_q <= right_change_d;
      tick_count_q   <= tick_count_d;
      left_edges_q   <= left_edges_d;
      right_edges_q  <= right_edges_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_data_q.left_position       <= dqcs_pkg::to_out32(left_count_d);
      out_data_q.right_position      <= dqcs_pkg::to_out32(right_count_d);
      out_data_q.left_window_change  <= dqcs_pkg::to_out32(left_change_d);
      out_data_q.right_window_change <= dqcs_pkg::to_out32(right_change_d);
      out_data_q.speed_update        <= update_d;
      out_data_q.left_a_edge_total   <= left_edges_d;
      out_data_q.right_a_edge_total  <= right_edges_d;
    end
  end

endmodule

[rtl/dqcs_decode.sv]
// x4 quadrature decode of one encoder: signed step and a-edge flag
`timescale 1ns / 1ps

module dqcs_decode (
  input  logic                                old_a_i,
  input  logic                                old_b_i,
  input  logic                                new_a_i,
  input  logic                                new_b_i,
  input  logic                                invert_i,
  output logic signed [dqcs_pkg::COUNT_WIDTH-1:0] step_o,
  output logic                                a_edge_o
);

  logic signed [2:0] step_a;
  logic signed [2:0] step_b;
  logic signed [2:0] step_sum;
  logic signed [2:0] step_fin;

  always_comb begin
    // a change first, then b change judged against the new a
    step_a   = (new_a_i == old_a_i) ? 3'sd0 : ((new_a_i == old_b_i) ? 3'sd1 : -3'sd1);
    step_b   = (new_b_i == old_b_i) ? 3'sd0 : ((new_a_i != new_b_i) ? 3'sd1 : -3'sd1);
    step_sum = step_a + step_b;
    step_fin = invert_i ? -step_sum : step_sum;
  end

  assign step_o   = {{(dqcs_pkg::COUNT_WIDTH-3){step_fin[2]}}, step_fin};
  assign a_edge_o = new_a_i ^ old_a_i;

endmodule

[sim/tb_dual_quadrature_counter_speed.sv]
// testbench for the dual quadrature counter: self-checking, with random encoder traffic
`timescale 1ns / 1ps

// the bench drives encoder samples through the valid/stall sample channel and
// checks every result transfer against a cycle-free model of the counter kept
// in a small scoreboard class. stimulus starts with hand-picked samples
// (priming, single and double steps, holds, ticks, zero window, window lowered
// mid-window) and then walks both encoders through gray-code sequences with
// some jumps and noise mixed in. the sender works in bursts, the receiver
// stalls on its own pattern, and once the receiver holds off long enough for
// the block to fill up and stall its input.

module tb_dual_quadrature_counter_speed;
  import dqcs_pkg::*;

  localparam int unsigned CLK_HALF_NS = 5;
  localparam int unsigned LIMIT_NS    = 5_000_000;
  localparam int unsigned SETTLE_CYC  = 4;     // settling margin after the last reading returns
  localparam int unsigned LONG_HOLD   = 300;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  // receiver stall behavior
  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_e;

  // expected-reading tracker: mirrors the counter state and queues the
  // reading every accepted sample should produce
  class counter_scoreboard;
    logic                  inv_left, inv_right;
    logic [WIN_WIDTH-1:0]  win_ticks;
    logic [3:0]            prev_levels;   // {right b, right a, left b, left a}
    bit                    primed;
    count_t                left_pos, right_pos, left_start, right_start;
    count_t                left_change, right_change;
    logic [31:0]           left_edges, right_edges;
    logic [TICK_WIDTH-1:0] ticks_seen;
    out_t                  readings_due[$];
    int                    errors;

    function new();
      inv_left     = 1'b1;
      inv_right    = 1'b0;
      win_ticks    = WINDOW_RESET;
      prev_levels  = '0;
      primed       = 1'b0;
      left_pos     = '0;
      right_pos    = '0;
      left_start   = '0;
      right_start  = '0;
      left_change  = '0;
      right_change = '0;
      left_edges   = '0;
      right_edges  = '0;
      ticks_seen   = '0;
      errors       = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_WIDTH-1:0] data);
      case (idx)
        REG_INVERT_LEFT:  inv_left  = data[0];
        REG_INVERT_RIGHT: inv_right = data[0];
        REG_WINDOW_TICKS: win_ticks = data[WIN_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    // x4 step of one encoder as a wrapping delta
    function count_t decode_step(logic oa, logic ob, logic na, logic nb, logic inv);
      count_t d;
      d = '0;
      if (na != oa) d = d + ((na == ob) ? count_t'(1) : '1);
      if (nb != ob) d = d + ((na != nb) ? count_t'(1) : '1);
      if (inv) d = -d;
      return d;
    endfunction

    function void note_sample(in_t s);
      out_t                  want;
      logic                  update;
      logic [CMP_WIDTH-1:0]  win;
      update = 1'b0;
      if (!primed) begin
        // priming sample: only the levels are taken
        primed = 1'b1;
      end else begin
        left_pos  = left_pos + decode_step(prev_levels[0], prev_levels[1],
                                           s.left_a, s.left_b, inv_left);
        right_pos = right_pos + decode_step(prev_levels[2], prev_levels[3],
                                            s.right_a, s.right_b, inv_right);
        if (s.left_a != prev_levels[0]) left_edges = left_edges + 1;
        if (s.right_a != prev_levels[2]) right_edges = right_edges + 1;
        if (s.ms_tick) begin
          win = CMP_WIDTH'(win_ticks);
          if (win == '0) win = CMP_WIDTH'(1);
          if (win > CMP_WIDTH'(TICK_MAX)) win = CMP_WIDTH'(TICK_MAX);
          if (ticks_seen != TICK_MAX) ticks_seen = ticks_seen + 1'b1;
          if (CMP_WIDTH'(ticks_seen) >= win) begin
            left_change  = left_pos - left_start;
            right_change = right_pos - right_start;
            left_start   = left_pos;
            right_start  = right_pos;
            ticks_seen   = '0;
            update       = 1'b1;
          end
        end
      end
      prev_levels = {s.right_b, s.right_a, s.left_b, s.left_a};

      want.left_position       = 32'(signed'(left_pos));
      want.right_position      = 32'(signed'(right_pos));
      want.left_window_change  = 32'(signed'(left_change));
      want.right_window_change = 32'(signed'(right_change));
      want.speed_update        = update;
      want.left_a_edge_total   = left_edges;
      want.right_a_edge_total  = right_edges;
      readings_due.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected 'h%08h, actual 'h%08h",
                 $time, name, want, got);
      end
    endfunction

    function void check_reading(out_t got);
      out_t want;
      if (readings_due.size() == 0) begin
        errors++;
        $display("%0t: result with no sample pending: expected none, actual 'h%h",
                 $time, got);
        return;
      end
      want = readings_due.pop_front();
      compare_field("left_position", want.left_position, got.left_position);
      compare_field("right_position", want.right_position, got.right_position);
      compare_field("left_window_change", want.left_window_change,
                    got.left_window_change);
      compare_field("right_window_change", want.right_window_change,
                    got.right_window_change);
      compare_field("speed_update", 32'(want.speed_update), 32'(got.speed_update));
      compare_field("left_a_edge_total", want.left_a_edge_total,
                    got.left_a_edge_total);
      compare_field("right_a_edge_total", want.right_a_edge_total,
                    got.right_a_edge_total);
    endfunction

    function int pending();
      return readings_due.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_INVERT_LEFT;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  counter_scoreboard sb = new();

  in_t      last_sent = '0;    // levels of the last accepted sample
  rx_mode_e rx_mode = RX_RANDOM;
  bit       hold_req = 1'b0;   // sender asks the receiver for a long hold-off
  int       burst_left = 0;

  dual_quadrature_counter_speed DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #(CLK_HALF_NS) clk = 1'b1;
    #(CLK_HALF_NS) clk = 1'b0;
  end

  // hard stop in case the handshake hangs
  initial begin
    #(LIMIT_NS);
    $display("FAIL dual_quadrature_counter_speed");
    $finish;
  end

  // receiver: stall pattern changes at the falling edge, long hold-off
  // counted here once the sender asks for it
  initial begin
    int hold_left;
    int rx_cycle;
    hold_left = 0;
    rx_cycle  = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          RX_FREE:    out_stall <= 1'b0;
          RX_RANDOM:  out_stall <= ($urandom_range(0, 99) < 40);
          default:    out_stall <= ((rx_cycle % 7) < 3);
        endcase
      end
      rx_cycle++;
    end
  end

  // every result transfer is checked at the rising edge it completes on
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_reading(out_data);
  end

  function automatic in_t sample_of(logic la, logic lb, logic ra, logic rb, logic t);
    in_t s;
    s.left_a  = la;
    s.left_b  = lb;
    s.right_a = ra;
    s.right_b = rb;
    s.ms_tick = t;
    return s;
  endfunction

  // gray position of a pair of levels: 00, 01, 11, 10
  function automatic int phase_of(logic a, logic b);
    case ({a, b})
      2'b00:   return 0;
      2'b01:   return 1;
      2'b11:   return 2;
      default: return 3;
    endcase
  endfunction

  function automatic logic [1:0] levels_of(int p);
    case (p)
      0:       return 2'b00;
      1:       return 2'b01;
      2:       return 2'b11;
      default: return 2'b10;
    endcase
  endfunction

  // mostly single gray steps either way, some holds, double steps and noise
  function automatic int move_phase(int p);
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return (p + 1) % 4;
    if (r < 70) return (p + 3) % 4;
    if (r < 82) return p;
    if (r < 94) return (p + 2) % 4;
    return $urandom_range(0, 3);
  endfunction

  function automatic in_t next_sample(int tick_pct);
    logic [1:0] l, r;
    l = levels_of(move_phase(phase_of(last_sent.left_a, last_sent.left_b)));
    r = levels_of(move_phase(phase_of(last_sent.right_a, last_sent.right_b)));
    return sample_of(l[1], l[0], r[1], r[0], $urandom_range(0, 99) < tick_pct);
  endfunction

  task automatic send_sample(input in_t s);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    sb.note_sample(s);
    last_sent = s;
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // stop offering and wait until every expected reading has come back
  task automatic drain_results(input int limit);
    int n;
    n = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0 && n < limit) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // register write; only called with nothing in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_WIDTH-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we   <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic run_random(input int n, input int tick_pct, input bit gaps);
    for (int i = 0; i < n; i++) begin
      if (gaps) begin
        if (burst_left == 0) begin
          idle_cycles($urandom_range(1, 6));
          burst_left = $urandom_range(1, 30);
        end
        burst_left--;
      end
      send_sample(next_sample(tick_pct));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: left inverted, 100-tick window; priming sample ticks
    send_sample(sample_of(1'b1, 1'b1, 1'b0, 1'b0, 1'b1));
    send_sample(sample_of(1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
    send_sample(sample_of(1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
    send_sample(sample_of(1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
    send_sample(sample_of(1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    send_sample(sample_of(1'b0, 1'b0, 1'b1, 1'b1, 1'b0)); // a and b together on both sides
    drain_results(1000);

    // right inverted, zero window acts as one tick
    write_reg(REG_INVERT_LEFT, 16'd0);
    write_reg(REG_INVERT_RIGHT, 16'd1);
    write_reg(REG_WINDOW_TICKS, 16'd0);
    send_sample(sample_of(1'b1, 1'b1, 1'b0, 1'b0, 1'b1));
    send_sample(sample_of(1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
    send_sample(sample_of(1'b0, 1'b1, 1'b0, 1'b1, 1'b1));
    send_sample(sample_of(1'b0, 1'b1, 1'b0, 1'b1, 1'b0)); // hold
    send_sample(sample_of(1'b0, 1'b1, 1'b0, 1'b1, 1'b1)); // hold on a tick: zero change
    send_sample(sample_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_sample(sample_of(1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
    send_sample(sample_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
    drain_results(1000);

    // window shortened after three ticks: closes on the next tick
    write_reg(REG_WINDOW_TICKS, 16'd5);
    send_sample(sample_of(1'b0, 1'b1, 1'b0, 1'b1, 1'b1));
    send_sample(sample_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_sample(sample_of(1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
    drain_results(1000);
    write_reg(REG_WINDOW_TICKS, 16'd2);
    send_sample(sample_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
    send_sample(sample_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    send_sample(sample_of(1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
    drain_results(1000);

    // short windows, bursty sender, random receiver
    write_reg(REG_INVERT_LEFT, 16'd1);
    write_reg(REG_INVERT_RIGHT, 16'd0);
    write_reg(REG_WINDOW_TICKS, 16'd3);
    rx_mode = RX_RANDOM;
    run_random(300, 30, 1'b1);
    // long receiver hold-off while the sender keeps offering back to back
    hold_req = 1'b1;
    run_random(60, 30, 1'b0);
    drain_results(5000);

    // longest window, then cut down to one tick with the window half open
    write_reg(REG_INVERT_LEFT, 16'd0);
    write_reg(REG_INVERT_RIGHT, 16'd1);
    write_reg(REG_WINDOW_TICKS, 16'hFFFF);
    rx_mode = RX_PATTERN;
    run_random(200, 50, 1'b1);
    drain_results(5000);
    write_reg(REG_WINDOW_TICKS, 16'd1);
    run_random(150, 40, 1'b1);
    drain_results(5000);

    // no idling on either side, with one full pause in the middle
    write_reg(REG_INVERT_LEFT, 16'd1);
    write_reg(REG_INVERT_RIGHT, 16'd1);
    write_reg(REG_WINDOW_TICKS, 16'd2);
    rx_mode = RX_FREE;
    run_random(125, 35, 1'b0);
    drain_results(5000);
    run_random(125, 35, 1'b0);
    drain_results(5000);

    write_reg(REG_INVERT_LEFT, 16'd0);
    write_reg(REG_INVERT_RIGHT, 16'd0);
    write_reg(REG_WINDOW_TICKS, 16'd8);
    rx_mode = RX_RANDOM;
    run_random(250, 60, 1'b1);
    drain_results(5000);

    if (sb.pending() != 0)
      $display("%0t: readings never returned: expected 0 pending, actual %0d",
               $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS dual_quadrature_counter_speed");
    end else begin
      $display("FAIL dual_quadrature_counter_speed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/dqcs_pkg.sv
rtl/dqcs_decode.sv
rtl/dual_quadrature_counter_speed.sv
sim/tb_dual_quadrature_counter_speed.sv
